>>> rtl/pva_pkg.sv
// Shared types and constants for the priority voice allocator.
// No dependencies; imported by the allocator core.
package pva_pkg;

  localparam int MAX_VOICES_DEF = 8;
  localparam int HANDLE_OFFSET  = 1;

  localparam int FUNC_W    = 2;
  localparam int PRIO_W    = 8;
  localparam int HANDLE_W  = 4;
  localparam int TIME_W    = 32;
  localparam int COUNT_W   = 4;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [COUNT_W-1:0] ACTIVE_VOICES_RST = 4'd8;

  typedef enum logic [FUNC_W-1:0] {
    FN_GRAB    = 2'd0,
    FN_PROBE   = 2'd1,
    FN_RELEASE = 2'd2,
    FN_QUERY   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NONE       = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_UNUSED     = 2'd3
  } status_t;

  localparam logic REG_ACTIVE_VOICES = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

>>> rtl/pva_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds per-voice priority and start time.
module pva_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/priority_voice_allocator_core.sv
// Priority voice allocator: busy flags in flops, priority/start time in pva_ram,
// one comparator walked over the voices by a small sequencer. Uses pva_pkg.
//
// channel  dir  handshake               payload
// s_*      in   s_tvalid/s_tready       s_tuser=func, s_tdata=prio,handle,now
// m_*      out  m_tvalid/m_tready       m_tdata=granted,handle_out,active,status
// apb      in   psel/penable/pwrite     reg 0 active_voices at byte addr 0
//
// Release/query, or grab/probe with no active voices: from the accept state
// to the done state, which loads the output register once it is free (accept, done).
// Grab/probe: accept, scan, write, done when a free voice ends the scan; accept, scan,
// drain, write, done when all active voices are busy (drain for the registered RAM read).
// Reset (rst, sync): clears busy flags and output valid, active_voices to 8.
// A result waits in the output register; the next word is accepted meanwhile,
// and its result waits in the done state until the register frees up.
module priority_voice_allocator_core #(
  parameter int MAX_VOICES = pva_pkg::MAX_VOICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] request_priority, [11:8] voice_handle, [43:12] now_time, rest zero
  input  logic [pva_pkg::IN_DATA_W-1:0]    s_tdata,
  // [1:0] func
  input  logic [pva_pkg::FUNC_W-1:0]       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] granted, [4:1] voice_handle_out, [5] active, [7:6] status
  output logic [pva_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pva_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pva_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pva_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import pva_pkg::*;

  localparam int IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W = $clog2(MAX_VOICES + 1);
  localparam int RAM_W = PRIO_W + TIME_W;

  state_t state, state_next;

  logic [COUNT_W-1:0]     active_voices;
  logic [MAX_VOICES-1:0]  busy;

  logic [FUNC_W-1:0]      req_func;
  logic [PRIO_W-1:0]      req_prio;
  logic [TIME_W-1:0]      req_time;
  logic [IDX_W-1:0]       req_hidx;

  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   cmp_pend;
  logic [IDX_W-1:0]       victim;
  logic                   victim_found;
  logic [TIME_W-1:0]      victim_bday;

  logic                   res_granted;
  logic [HANDLE_W-1:0]    res_handle;
  logic                   res_active;
  logic [STATUS_W-1:0]    res_status;

  logic [31:0]            n_wide;
  logic [CNT_W-1:0]       n;
  logic                   in_acc;
  logic                   cfg_wr;
  logic [FUNC_W-1:0]      in_func;
  logic [PRIO_W-1:0]      in_prio;
  logic [HANDLE_W-1:0]    in_handle;
  logic [TIME_W-1:0]      in_time;
  logic                   h_valid;
  logic [31:0]            h_wide;
  logic [IDX_W-1:0]       h_idx;
  logic                   last_idx;
  logic [PRIO_W-1:0]      rd_prio;
  logic [TIME_W-1:0]      rd_bday;
  logic [RAM_W-1:0]       rd_data;
  logic                   cmp_hit;
  logic                   ram_we;
  logic [31:0]            hout_wide;
  logic                   out_free;

  assign in_func   = s_tuser;
  assign in_prio   = s_tdata[7:0];
  assign in_handle = s_tdata[11:8];
  assign in_time   = s_tdata[43:12];

  assign n_wide = ({28'd0, active_voices} > 32'(MAX_VOICES)) ? 32'(MAX_VOICES)
                                                              : {28'd0, active_voices};
  assign n      = n_wide[CNT_W-1:0];

  assign h_wide  = {28'd0, in_handle} - 32'(HANDLE_OFFSET);
  assign h_valid = (in_handle != '0) && ({28'd0, in_handle} <= 32'(n));
  assign h_idx   = h_wide[IDX_W-1:0];

  assign last_idx = (32'(idx) + 32'd1) == 32'(n);

  assign rd_prio = rd_data[RAM_W-1:TIME_W];
  assign rd_bday = rd_data[TIME_W-1:0];
  assign cmp_hit = cmp_pend && (rd_prio <= req_prio) &&
                   (!victim_found || (rd_bday < victim_bday));

  assign ram_we    = (state == S_WRITE) && victim_found;
  assign hout_wide = 32'(victim) + 32'(HANDLE_OFFSET);
  assign out_free  = !m_tvalid || m_tready;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ACTIVE_VOICES) ? {28'd0, active_voices} : '0;

  pva_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_VOICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (victim),
    .wdata ({req_prio, req_time}),
    .raddr (idx),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_func == FN_GRAB || in_func == FN_PROBE) && n != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (!busy[idx]) begin
          state_next = S_WRITE;
        end else if (last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_WRITE;
      S_WRITE: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active_voices <= ACTIVE_VOICES_RST;
      busy          <= '0;
      m_tvalid      <= 1'b0;
      cmp_pend      <= 1'b0;
      victim_found  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr && paddr[2] == REG_ACTIVE_VOICES) begin
        active_voices <= pwdata[COUNT_W-1:0];
      end

      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            req_func     <= in_func;
            req_prio     <= in_prio;
            req_time     <= in_time;
            req_hidx     <= h_idx;
            idx          <= '0;
            cmp_pend     <= 1'b0;
            victim_found <= 1'b0;
            res_granted  <= 1'b0;
            res_handle   <= '0;
            if (in_func == FN_GRAB || in_func == FN_PROBE) begin
              res_active <= 1'b0;
              res_status <= (n == '0) ? ST_NONE : ST_OK;
            end else if (!h_valid) begin
              res_active <= 1'b0;
              res_status <= ST_BAD_HANDLE;
            end else if (in_func == FN_RELEASE) begin
              res_active  <= 1'b0;
              res_status  <= ST_OK;
              busy[h_idx] <= 1'b0;
            end else begin
              res_active <= busy[h_idx];
              res_status <= ST_OK;
            end
          end
        end
        S_SCAN, S_DRAIN: begin
          if (state == S_SCAN && !busy[idx]) begin
            victim       <= idx;
            victim_found <= 1'b1;
          end else if (cmp_hit) begin
            victim       <= cmp_idx;
            victim_bday  <= rd_bday;
            victim_found <= 1'b1;
          end
          cmp_pend <= (state == S_SCAN) && busy[idx];
          if (state == S_SCAN && busy[idx]) begin
            cmp_idx <= idx;
            if (!last_idx) begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_WRITE: begin
          if (victim_found) begin
            busy[victim] <= (req_func == FN_GRAB);
            res_granted  <= 1'b1;
            res_handle   <= hout_wide[HANDLE_W-1:0];
          end else begin
            res_status <= ST_NONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tdata <= {res_status, res_active, res_handle, res_granted};
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (32'(idx) < 32'(n)))
    else $error("scan index beyond active count");

  a_victim_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && victim_found) |-> (32'(victim) < 32'(n)))
    else $error("victim beyond active count");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_func == FN_RELEASE && h_valid) |=> !busy[req_hidx])
    else $error("released voice still busy");

  a_grab_sets_busy: assert property (@(posedge clk) disable iff (rst)
    (ram_we && req_func == FN_GRAB) |=> busy[$past(victim)])
    else $error("grabbed voice not marked busy");

  a_granted_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[7:6] == ST_OK && !m_tdata[5]))
    else $error("granted result with bad status");
`endif

endmodule
